@@ rtl/core/rmq_pkg.sv @@
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared types and constants for the rotation matrix to quaternion block.
// ----------------------------------------------------------------------------
package rmq_pkg;

    // number of quaternion components worked in parallel (w, x, y, z)
    localparam int LANES = 4;

    // lane order inside the root chain
    localparam int LANE_W = 0;
    localparam int LANE_X = 1;
    localparam int LANE_Y = 2;
    localparam int LANE_Z = 3;

    // largest magnitude a component can carry
    localparam logic [14:0] MAG_MAX = 15'h7FFF;

    // control that travels beside the root data through the chain
    typedef struct packed {
        logic valid;
        logic neg_x;
        logic neg_y;
        logic neg_z;
    } t_ctl;

endpackage

@@ rtl/core/rmq_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// rmq_sqrt_cell
// One digit step of a restoring square root for all four lanes. Each cell
// settles one root bit per lane and hands the partial result to the next.
// ----------------------------------------------------------------------------
module rmq_sqrt_cell
    import rmq_pkg::*;
#(
    parameter int RB = 16,
    parameter int VW = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_ctl                          i_ctl,
    input  logic [LANES-1:0][VW-1:0]      i_rad,
    input  logic [LANES-1:0][RB+1:0]      i_rem,
    input  logic [LANES-1:0][RB-1:0]      i_root,
    output t_ctl                          o_ctl,
    output logic [LANES-1:0][VW-1:0]      o_rad,
    output logic [LANES-1:0][RB+1:0]      o_rem,
    output logic [LANES-1:0][RB-1:0]      o_root
);

    t_ctl                       r_ctl;
    logic [LANES-1:0][VW-1:0]   r_rad, n_rad;
    logic [LANES-1:0][RB+1:0]   r_rem, n_rem;
    logic [LANES-1:0][RB-1:0]   r_root, n_root;

    // trial subtract per lane: bring down two radicand bits, try 4*root+1
    always_comb begin
        logic [RB+1:0] rem_sh;
        logic [RB+1:0] trial;
        logic          ge;
        for (int l = 0; l < LANES; l++) begin
            rem_sh    = {i_rem[l][RB-1:0], i_rad[l][VW-1 -: 2]};
            trial     = {i_root[l], 2'b01};
            ge        = (rem_sh >= trial);
            n_rem[l]  = ge ? (rem_sh - trial) : rem_sh;
            n_root[l] = {i_root[l][RB-2:0], ge};
            n_rad[l]  = {i_rad[l][VW-3:0], 2'b00};
        end
    end

    // control beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_rad  <= n_rad;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_ctl  = r_ctl;
    assign o_rad  = r_rad;
    assign o_rem  = r_rem;
    assign o_root = r_root;

endmodule

@@ rtl/core/rotation_matrix_to_quaternion.sv @@
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Converts a 3x3 rotation matrix in signed fixed point to a unit quaternion.
// ----------------------------------------------------------------------------
// Usage:
//   Drive the nine matrix elements on i_m00..i_m22 and raise start. A beat is
//   taken at each rising edge with start high and busy low; busy is low
//   whenever the block is out of reset, so a new matrix can enter every cycle.
//   Each beat gives one result on o_quat_w/x/y/z, marked by o_done for exactly
//   one cycle. The receiver cannot stall; results leave in input order.
//   Path: an accepted beat passes the front-end register, the RB root cells
//   and the output register that drives o_done and the result, where
//   RB = (max(FRAC_BITS,17) + 1 + FRAC_BITS + 1) / 2 is the root width, one
//   cell per root bit. Throughput is one beat per cycle, set by the fully
//   pipelined root chain.
//   A component magnitude is floor(sqrt(max(0, 1 +/- m00 +/- m11 +/- m22)
//   * 2^F) / 2), saturated to 32767; the x, y, z signs come from m21-m12,
//   m02-m20 and m10-m01, a zero difference counting as positive.
//   Reset (synchronous, active low) empties the pipeline; busy is high
//   while reset is applied.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion
    import rmq_pkg::*;
#(
    parameter int FRAC_BITS = 14
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] i_m00,
    input  logic signed [15:0] i_m01,
    input  logic signed [15:0] i_m02,
    input  logic signed [15:0] i_m10,
    input  logic signed [15:0] i_m11,
    input  logic signed [15:0] i_m12,
    input  logic signed [15:0] i_m20,
    input  logic signed [15:0] i_m21,
    input  logic signed [15:0] i_m22,
    output logic               o_done,
    output logic [14:0]        o_quat_w,
    output logic signed [15:0] o_quat_x,
    output logic signed [15:0] o_quat_y,
    output logic signed [15:0] o_quat_z
);

    // clamped sum width, signed sum width, root and radicand widths
    localparam int SB  = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 1;
    localparam int SSW = SB + 1;
    localparam int RB  = (SB + FRAC_BITS + 1) / 2;
    localparam int VW  = 2 * RB;
    localparam int MW  = (RB > 16) ? RB : 16;
    localparam int LAT = RB + 2;

    logic accept;

    assign busy   = ~i_rst_n;
    assign accept = start & ~busy;

    // ------------------------------------------------------------------
    // front end: four signed sums, clamp, radicand and sign bits
    // ------------------------------------------------------------------
    logic signed [SSW-1:0]     one_fx;
    logic signed [SSW-1:0]     a00, a11, a22;
    logic signed [SSW-1:0]     sum [LANES];
    logic signed [16:0]        d_x, d_y, d_z;
    logic [LANES-1:0][VW-1:0]  n_rad;
    t_ctl                      n_ctl;

    assign one_fx = SSW'(1) <<< FRAC_BITS;
    assign a00    = SSW'(i_m00);
    assign a11    = SSW'(i_m11);
    assign a22    = SSW'(i_m22);

    always_comb begin
        sum[LANE_W] = one_fx + a00 + a11 + a22;
        sum[LANE_X] = one_fx + a00 - a11 - a22;
        sum[LANE_Y] = one_fx - a00 + a11 - a22;
        sum[LANE_Z] = one_fx - a00 - a11 + a22;
        for (int l = 0; l < LANES; l++) begin
            if (sum[l][SSW-1]) begin
                n_rad[l] = '0;
            end else begin
                n_rad[l] = VW'(sum[l][SB-1:0]) << FRAC_BITS;
            end
        end
    end

    assign d_x = 17'(i_m21) - 17'(i_m12);
    assign d_y = 17'(i_m02) - 17'(i_m20);
    assign d_z = 17'(i_m10) - 17'(i_m01);

    always_comb begin
        n_ctl.valid = accept;
        n_ctl.neg_x = d_x[16];
        n_ctl.neg_y = d_y[16];
        n_ctl.neg_z = d_z[16];
    end

    t_ctl                      r_fe_ctl;
    logic [LANES-1:0][VW-1:0]  r_fe_rad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fe_ctl <= '0;
        end else begin
            r_fe_ctl <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fe_rad <= n_rad;
    end

    // ------------------------------------------------------------------
    // root chain: one cell per root bit
    // ------------------------------------------------------------------
    t_ctl                      c_ctl  [RB+1];
    logic [LANES-1:0][VW-1:0]  c_rad  [RB+1];
    logic [LANES-1:0][RB+1:0]  c_rem  [RB+1];
    logic [LANES-1:0][RB-1:0]  c_root [RB+1];

    assign c_ctl[0]  = r_fe_ctl;
    assign c_rad[0]  = r_fe_rad;
    assign c_rem[0]  = '0;
    assign c_root[0] = '0;

    for (genvar k = 0; k < RB; k++) begin : g_cell
        rmq_sqrt_cell #(
            .RB (RB),
            .VW (VW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (c_ctl[k]),
            .i_rad   (c_rad[k]),
            .i_rem   (c_rem[k]),
            .i_root  (c_root[k]),
            .o_ctl   (c_ctl[k+1]),
            .o_rad   (c_rad[k+1]),
            .o_rem   (c_rem[k+1]),
            .o_root  (c_root[k+1])
        );
    end

    // ------------------------------------------------------------------
    // back end: halve, saturate, apply signs
    // ------------------------------------------------------------------
    logic [LANES-1:0][14:0] mag;
    logic [MW-1:0]          half;
    t_ctl                   tail;

    assign tail = c_ctl[RB];

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            half   = MW'(c_root[RB][l] >> 1);
            mag[l] = (half > MW'(MAG_MAX)) ? MAG_MAX : half[14:0];
        end
    end

    logic               r_done;
    logic [14:0]        r_quat_w;
    logic signed [15:0] r_quat_x, r_quat_y, r_quat_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= tail.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quat_w <= mag[LANE_W];
        r_quat_x <= tail.neg_x ? -{1'b0, mag[LANE_X]} : {1'b0, mag[LANE_X]};
        r_quat_y <= tail.neg_y ? -{1'b0, mag[LANE_Y]} : {1'b0, mag[LANE_Y]};
        r_quat_z <= tail.neg_z ? -{1'b0, mag[LANE_Z]} : {1'b0, mag[LANE_Z]};
    end

    assign o_done   = r_done;
    assign o_quat_w = r_quat_w;
    assign o_quat_x = r_quat_x;
    assign o_quat_y = r_quat_y;
    assign o_quat_z = r_quat_z;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    // every accepted beat leaves after the fixed latency
    a_latency_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LAT o_done)
        else $error("accepted beat did not produce a result");

    // no result without a matching accepted beat
    a_latency_bwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(accept, LAT))
        else $error("result strobe without accepted beat");

    // saturation happens before the sign, so -32768 never appears
    a_no_min_neg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_quat_x != 16'sh8000) && (o_quat_y != 16'sh8000)
                   && (o_quat_z != 16'sh8000))
        else $error("component below -32767");

endmodule

@@ tb/rotation_matrix_to_quaternion_tb.sv @@
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_tb
// Self-checking bench for the matrix to quaternion converter. Directed poses
// (identity, half turns, quarter turns, extreme and clamped sums, zero sign
// differences) are followed by random matrices. Every beat taken is predicted
// in fixed point and each o_done result is checked in order, field by field.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_tb;
    import rmq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC        = 14;
    localparam int RAND_BEATS  = 400;
    localparam int SETTLE_CYC  = 40;
    localparam int DRAIN_LIMIT = 2000;

    typedef struct {
        logic signed [15:0] m [3][3];
    } t_matrix;

    typedef struct {
        logic [14:0]        w;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } t_quat;

    // ------------------------------------------------------------------------
    // Scoreboard: predicts a quaternion per accepted matrix, checks in order
    // ------------------------------------------------------------------------
    class quat_scoreboard;
        t_quat pending[$];
        int    fails;
        int    reports;
        int    matrices;
        int    checked;
        int    zero_mags;
        int    zero_diffs;

        // floor integer square root, one result bit per pass
        function automatic longint unsigned int_sqrt(input longint unsigned v);
            longint unsigned res;
            longint unsigned step;
            res  = 0;
            step = 64'd1 << 62;
            while (step > v) step >>= 2;
            while (step != 0) begin
                if (v >= res + step) begin
                    v  -= res + step;
                    res = (res >> 1) + step;
                end else begin
                    res >>= 1;
                end
                step >>= 2;
            end
            return res;
        endfunction

        // half root of max(0, one + a + b + c), saturated
        function automatic logic [14:0] half_root(input longint a, input longint b,
                                                  input longint c);
            longint          s;
            longint unsigned r;
            s = (longint'(1) <<< FRAC) + a + b + c;
            if (s < 0) s = 0;
            r = int_sqrt(longint'(s) << FRAC) >> 1;
            if (r > 64'd32767) r = 64'd32767;
            return r[14:0];
        endfunction

        // zero difference counts as positive
        function automatic logic signed [15:0] apply_sign(input logic [14:0] mag,
                                                          input longint diff);
            logic [15:0] wide;
            wide = {1'b0, mag};
            if (diff < 0) return -wide;
            return wide;
        endfunction

        function automatic t_quat predict_quat(input t_matrix mat);
            longint e [3][3];
            t_quat  q;
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    e[r][c] = longint'(mat.m[r][c]);
            q.w = half_root(e[0][0], e[1][1], e[2][2]);
            q.x = apply_sign(half_root(e[0][0], -e[1][1], -e[2][2]), e[2][1] - e[1][2]);
            q.y = apply_sign(half_root(-e[0][0], e[1][1], -e[2][2]), e[0][2] - e[2][0]);
            q.z = apply_sign(half_root(-e[0][0], -e[1][1], e[2][2]), e[1][0] - e[0][1]);
            if (q.w == 0) zero_mags++;
            if (q.x == 0) zero_mags++;
            if (q.y == 0) zero_mags++;
            if (q.z == 0) zero_mags++;
            if (mat.m[2][1] == mat.m[1][2] || mat.m[0][2] == mat.m[2][0] ||
                mat.m[1][0] == mat.m[0][1]) zero_diffs++;
            return q;
        endfunction

        function void note_matrix(input t_matrix mat);
            pending.push_back(predict_quat(mat));
            matrices++;
        endfunction

        function void check_quat(input t_quat got);
            t_quat exp_q;
            checked++;
            if (pending.size() == 0) begin
                fails++;
                if (reports < 10)
                    $display("ERROR: result w=%0d x=%0d y=%0d z=%0d with no matrix pending",
                             got.w, got.x, got.y, got.z);
                reports++;
                return;
            end
            exp_q = pending.pop_front();
            if (got.w !== exp_q.w || got.x !== exp_q.x ||
                got.y !== exp_q.y || got.z !== exp_q.z) begin
                fails++;
                if (reports < 10)
                    $display("ERROR: result %0d exp w=%0d x=%0d y=%0d z=%0d got w=%0d x=%0d y=%0d z=%0d",
                             checked, exp_q.w, exp_q.x, exp_q.y, exp_q.z,
                             got.w, got.x, got.y, got.z);
                reports++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, ports, DUT
    // ------------------------------------------------------------------------
    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic signed [15:0] i_m00, i_m01, i_m02, i_m10, i_m11, i_m12, i_m20, i_m21, i_m22;
    logic               o_done;
    logic [14:0]        o_quat_w;
    logic signed [15:0] o_quat_x, o_quat_y, o_quat_z;

    quat_scoreboard board = new();
    int             directed_beats;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    rotation_matrix_to_quaternion #(.FRAC_BITS(FRAC)) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_m00    (i_m00),
        .i_m01    (i_m01),
        .i_m02    (i_m02),
        .i_m10    (i_m10),
        .i_m11    (i_m11),
        .i_m12    (i_m12),
        .i_m20    (i_m20),
        .i_m21    (i_m21),
        .i_m22    (i_m22),
        .o_done   (o_done),
        .o_quat_w (o_quat_w),
        .o_quat_x (o_quat_x),
        .o_quat_y (o_quat_y),
        .o_quat_z (o_quat_z)
    );

    // ------------------------------------------------------------------------
    // Monitors: input beat taken, result beat out
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_matrix seen;
        t_quat   got;
        seen.m[0][0] = i_m00; seen.m[0][1] = i_m01; seen.m[0][2] = i_m02;
        seen.m[1][0] = i_m10; seen.m[1][1] = i_m11; seen.m[1][2] = i_m12;
        seen.m[2][0] = i_m20; seen.m[2][1] = i_m21; seen.m[2][2] = i_m22;
        got.w = o_quat_w;
        got.x = o_quat_x;
        got.y = o_quat_y;
        got.z = o_quat_z;
        if (i_rst_n === 1'b1 && start === 1'b1 && busy === 1'b0) board.note_matrix(seen);
        if (i_rst_n === 1'b1 && o_done === 1'b1) board.check_quat(got);
    end

    // ------------------------------------------------------------------------
    // Driver tasks; called right after a rising edge
    // ------------------------------------------------------------------------
    task automatic put_matrix(input t_matrix mat);
        i_m00 <= mat.m[0][0]; i_m01 <= mat.m[0][1]; i_m02 <= mat.m[0][2];
        i_m10 <= mat.m[1][0]; i_m11 <= mat.m[1][1]; i_m12 <= mat.m[1][2];
        i_m20 <= mat.m[2][0]; i_m21 <= mat.m[2][1]; i_m22 <= mat.m[2][2];
    endtask

    task automatic send_beat(input t_matrix mat);
        put_matrix(mat);
        start <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    // start low with junk on the data lines
    task automatic idle_cycles(input int n);
        t_matrix junk;
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                junk.m[r][c] = 16'($urandom);
        put_matrix(junk);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    function automatic t_matrix make_matrix(input int a00, input int a01, input int a02,
                                            input int a10, input int a11, input int a12,
                                            input int a20, input int a21, input int a22);
        t_matrix mat;
        mat.m[0][0] = 16'(a00); mat.m[0][1] = 16'(a01); mat.m[0][2] = 16'(a02);
        mat.m[1][0] = 16'(a10); mat.m[1][1] = 16'(a11); mat.m[1][2] = 16'(a12);
        mat.m[2][0] = 16'(a20); mat.m[2][1] = 16'(a21); mat.m[2][2] = 16'(a22);
        return mat;
    endfunction

    function automatic logic signed [15:0] pick_extreme();
        case ($urandom_range(4))
            0: return -16'sd32768;
            1: return -16'sd16384;
            2: return 16'sd0;
            3: return 16'sd16384;
            default: return 16'sd32767;
        endcase
    endfunction

    // random matrix drawn from one of several shapes
    function automatic t_matrix random_matrix();
        t_matrix mat;
        int      shape;
        shape = $urandom_range(5);
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++) begin
                if (shape <= 1)
                    mat.m[r][c] = 16'($urandom);
                else if (shape <= 3 || shape == 4)
                    mat.m[r][c] = 16'($urandom_range(32768) - 16384);
                else
                    mat.m[r][c] = ($urandom_range(1) != 0) ? pick_extreme()
                                                           : 16'($urandom);
            end
        // symmetric off-diagonals give zero sign differences
        if (shape == 4) begin
            mat.m[1][0] = mat.m[0][1];
            mat.m[2][0] = mat.m[0][2];
            mat.m[2][1] = mat.m[1][2];
        end
        return mat;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        t_matrix poses[$];
        int      drain;
        start   <= 1'b0;
        i_rst_n <= 1'b0;
        put_matrix(make_matrix(0, 0, 0, 0, 0, 0, 0, 0, 0));
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed poses
        poses.push_back(make_matrix(16384, 0, 0, 0, 16384, 0, 0, 0, 16384));
        poses.push_back(make_matrix(0, 0, 0, 0, 0, 0, 0, 0, 0));
        poses.push_back(make_matrix(32767, 32767, 32767, 32767, 32767, 32767,
                                    32767, 32767, 32767));
        poses.push_back(make_matrix(-32768, -32768, -32768, -32768, -32768, -32768,
                                    -32768, -32768, -32768));
        poses.push_back(make_matrix(16384, 0, 0, 0, -16384, 0, 0, 0, -16384));
        poses.push_back(make_matrix(-16384, 0, 0, 0, 16384, 0, 0, 0, -16384));
        poses.push_back(make_matrix(-16384, 0, 0, 0, -16384, 0, 0, 0, 16384));
        poses.push_back(make_matrix(16384, 0, 0, 0, 0, -16384, 0, 16384, 0));
        poses.push_back(make_matrix(16384, 0, 0, 0, 0, 16384, 0, -16384, 0));
        poses.push_back(make_matrix(0, 0, 16384, 0, 16384, 0, -16384, 0, 0));
        poses.push_back(make_matrix(0, 0, -16384, 0, 16384, 0, 16384, 0, 0));
        poses.push_back(make_matrix(0, -16384, 0, 16384, 0, 0, 0, 0, 16384));
        poses.push_back(make_matrix(0, 16384, 0, -16384, 0, 0, 0, 0, 16384));
        poses.push_back(make_matrix(-32768, 32767, 32767, -32768, -32768, 32767,
                                    -32768, -32768, -32768));
        poses.push_back(make_matrix(-16384, 5000, -7000, 5000, -16384, 123,
                                    -7000, 123, -16384));
        poses.push_back(make_matrix(32767, 1, -1, -1, -32768, 1, 1, -1, -32768));
        poses.push_back(make_matrix(16'h5555, 16'h5555, 16'h5555, 16'h5555, 16'h5555,
                                    16'h5555, 16'h5555, 16'h5555, 16'h5555));
        poses.push_back(make_matrix(16'hAAAA, 16'hAAAA, 16'hAAAA, 16'hAAAA, 16'hAAAA,
                                    16'hAAAA, 16'hAAAA, 16'hAAAA, 16'hAAAA));
        poses.push_back(make_matrix(32767, 32767, -32768, -32768, 32767, 32767,
                                    32767, -32768, 32767));
        poses.push_back(make_matrix(-32768, -100, 200, 300, 32767, -400,
                                    -200, 500, -32768));
        directed_beats = poses.size();
        foreach (poses[k]) send_beat(poses[k]);

        // random matrices; a long stretch in the middle runs back to back
        for (int k = 0; k < RAND_BEATS; k++) begin
            if ((k < 150 || k >= 260) && $urandom_range(99) < 23)
                idle_cycles($urandom_range(3, 1));
            send_beat(random_matrix());
        end
        start <= 1'b0;

        drain = 0;
        while (board.pending.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (board.pending.size() != 0) begin
            $display("ERROR: %0d quaternions never came out", board.pending.size());
            board.fails += board.pending.size();
        end

        $display("Sent %0d matrices (%0d directed, %0d random), checked %0d quaternions.",
                 board.matrices, directed_beats, RAND_BEATS, board.checked);
        $display("Zero components seen: %0d; matrices with a zero sign difference: %0d.",
                 board.zero_mags, board.zero_diffs);
        if (board.fails == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // watchdog
    initial begin
        #200000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/rmq_pkg.sv
rtl/core/rmq_sqrt_cell.sv
rtl/core/rotation_matrix_to_quaternion.sv
tb/rotation_matrix_to_quaternion_tb.sv
